/* hdl/signed_window_digit_recoder_macros.svh */
// assertion macros shared by the recoder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef SIGNED_WINDOW_DIGIT_RECODER_MACROS_SVH
`define SIGNED_WINDOW_DIGIT_RECODER_MACROS_SVH

// same-cycle implication
`define SWDR_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWDR_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/swdr_pkg.sv */
// types and constants of the signed window digit recoder
// no dependencies; imported by every recoder module
`default_nettype none

package swdr_pkg;

   localparam int LIMB_W      = 64;
   localparam int REQ_DATA_W  = 4 * LIMB_W;
   localparam int WIDTH_W     = 4;
   localparam int LEN_W       = 9;
   localparam int CSR_DATA_W  = 9;
   localparam int CSR_ADDR_W  = 1;
   localparam int RAW_W       = 14;
   localparam int DIGIT_W     = 15;
   localparam int INDEX_W     = 6;
   localparam int OFF_W       = 10;
   localparam int RSP_DATA_W  = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALAR_LENGTH = 1'b1;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd7;
   localparam logic [LEN_W-1:0]   LEN_RESET   = 9'd256;
   localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 4'd4;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 4'd14;
   localparam logic [WIDTH_W-1:0] SIGNED_FROM = 4'd7;

   typedef struct packed {
      logic                 load;
      logic                 step;
      logic                 signed_digits;
      logic                 in_range;
      logic                 last;
      logic [WIDTH_W-1:0]   width;
   } ctrl_type;

endpackage

`default_nettype wire

/* hdl/swdr_shifter.sv */
// scalar shift register: loads one scalar, drops one window of bits per step
// depends on swdr_pkg
`default_nettype none

module swdr_shifter #(
   parameter int SCALAR_WIDTH = 256
) (
   input  wire logic                            clock,
   input  wire logic                            load,
   input  wire logic                            shift,
   input  wire logic [swdr_pkg::WIDTH_W-1:0]    width,
   input  wire logic [SCALAR_WIDTH-1:0]         load_data,
   output logic      [swdr_pkg::RAW_W-1:0]      raw
);
   import swdr_pkg::*;

   logic [SCALAR_WIDTH-1:0] sr_ff;
   logic [SCALAR_WIDTH-1:0] sr_in;

   always_comb begin
      sr_in = sr_ff;
      if (load) begin
         sr_in = load_data;
      end else if (shift) begin
         // zeros come in from the top
         sr_in = sr_ff >> width;
      end
   end

   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
   end

   assign raw = sr_ff[RAW_W-1:0];

endmodule

`default_nettype wire

/* hdl/swdr_recode.sv */
// window digit recoding with carry, and the result output register
// depends on swdr_pkg
`default_nettype none

module swdr_recode (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire swdr_pkg::ctrl_type              ctrl,
   input  wire logic [swdr_pkg::RAW_W-1:0]      raw,
   input  wire logic [swdr_pkg::INDEX_W-1:0]    index,
   input  wire logic                            out_ready,
   output logic                                 can_step,
   output logic                                 out_valid,
   output logic      [swdr_pkg::DIGIT_W-1:0]    out_digit,
   output logic      [swdr_pkg::INDEX_W-1:0]    out_index,
   output logic                                 out_last
);
   import swdr_pkg::*;

   logic               carry_ff, carry_in;
   logic               valid_ff, valid_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [INDEX_W-1:0] index_ff;
   logic               last_ff;

   logic [DIGIT_W-1:0] mask, half, full, sel, sum;

   always_comb begin
      mask = (DIGIT_W'(1) << ctrl.width) - DIGIT_W'(1);
      half = DIGIT_W'(1) << (ctrl.width - WIDTH_W'(1));
      full = DIGIT_W'(1) << ctrl.width;
      // windows starting at or past the length read as zero
      sel  = ctrl.in_range ? (DIGIT_W'(raw) & mask) : '0;
      sum  = sel + DIGIT_W'(carry_ff);
      digit_in = sum;
      carry_in = carry_ff;
      if (ctrl.load) begin
         carry_in = 1'b0;
      end else if (ctrl.step) begin
         carry_in = 1'b0;
         if (ctrl.signed_digits && (sum > half)) begin
            digit_in = sum - full;
            carry_in = 1'b1;
         end
      end
   end

   assign can_step = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.step) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         carry_ff <= carry_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         digit_ff <= digit_in;
         index_ff <= index;
         last_ff  <= ctrl.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_digit = digit_ff;
   assign out_index = index_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire

/* hdl/signed_window_digit_recoder.sv */
// top level of the signed window digit recoder: configuration, window sequencing
// depends on swdr_pkg, swdr_shifter and swdr_recode
//
// Usage:
//  req_* takes one scalar per item, four 64-bit limbs in req_tdata, limb 0 lowest.
//  rsp_* gives one item per window, least significant window first: digit and
//  window index in rsp_tdata, rsp_tlast high on the scalar's top window.
//  csr_* writes window_width (index 0) and scalar_length (index 1); write only
//  while the block is idle.
//  Window count is ceil(L/c) below width 7 and floor(L/c)+1 from width 7 on,
//  capped at MAX_WINDOWS.
//  A taken scalar is loaded into the shift register; its first window then goes
//  into the output register. Throughput: one window per cycle from the shift
//  register, which drops c bits a step, while the output register can take it.
//  req_tready stays low while windows are still being cut; the next scalar is
//  taken as soon as the top window is in the output register.
//  When rsp_tready is low, the output register holds and the shift register
//  waits.
//  Reset (synchronous) empties the output register, drops any scalar in work,
//  and sets width 7 and length 256.
`default_nettype none

module signed_window_digit_recoder #(
   parameter int SCALAR_WIDTH = 256,
   parameter int MAX_WINDOWS  = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // limbs 0, 1, 2, 3 from the lowest bit up
   input  wire logic [swdr_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // window_digit, window_index, zero fill from the lowest bit up
   output logic      [swdr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                      rsp_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic                                 csr_we,
   input  wire logic [swdr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  wire logic [swdr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import swdr_pkg::*;

   localparam logic [INDEX_W-1:0] IdxLast = INDEX_W'(MAX_WINDOWS - 1);
   localparam logic [LEN_W-1:0]   LenMax  = LEN_W'(SCALAR_WIDTH);

   logic [WIDTH_W-1:0] width_ff;
   logic [LEN_W-1:0]   length_ff;
   logic               busy_ff, busy_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;

   logic [WIDTH_W-1:0] width_c;
   logic [LEN_W-1:0]   len_c;
   logic [OFF_W-1:0]   len_ext, next_off;
   logic               more;
   logic               can_step;
   logic [RAW_W-1:0]   raw;
   ctrl_type           ctrl;
   logic [DIGIT_W-1:0] out_digit;
   logic [INDEX_W-1:0] out_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         length_ff <= LEN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_WINDOW_WIDTH:  width_ff  <= csr_wdata[WIDTH_W-1:0];
            REG_SCALAR_LENGTH: length_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      width_c = width_ff;
      if (width_ff < WIDTH_MIN) width_c = WIDTH_MIN;
      if (width_ff > WIDTH_MAX) width_c = WIDTH_MAX;
      len_c = length_ff;
      if (length_ff == '0) len_c = LEN_W'(1);
      if (length_ff > LenMax) len_c = LenMax;
   end

   assign len_ext  = OFF_W'(len_c);
   assign next_off = off_ff + OFF_W'(width_c);

   always_comb begin
      ctrl.width         = width_c;
      ctrl.signed_digits = (width_c >= SIGNED_FROM);
      ctrl.in_range      = (off_ff < len_ext);
      // signed mode also emits the window that starts exactly at the length
      more = ctrl.signed_digits ? (next_off <= len_ext) : (next_off < len_ext);
      ctrl.last          = !more || (idx_ff == IdxLast);
      ctrl.load          = req_tvalid && req_tready;
      ctrl.step          = busy_ff && can_step;
   end

   always_comb begin
      busy_in = busy_ff;
      off_in  = off_ff;
      idx_in  = idx_ff;
      if (ctrl.load) begin
         busy_in = 1'b1;
         off_in  = '0;
         idx_in  = '0;
      end else if (ctrl.step) begin
         busy_in = !ctrl.last;
         off_in  = next_off;
         idx_in  = idx_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         off_ff  <= '0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         off_ff  <= off_in;
         idx_ff  <= idx_in;
      end
   end

   assign req_tready = !busy_ff;

   swdr_shifter #(
      .SCALAR_WIDTH (SCALAR_WIDTH)
   ) u_shifter (
      .clock     (clock),
      .load      (ctrl.load),
      .shift     (ctrl.step),
      .width     (width_c),
      .load_data (req_tdata[SCALAR_WIDTH-1:0]),
      .raw       (raw)
   );

   swdr_recode u_recode (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .raw       (raw),
      .index     (idx_ff),
      .out_ready (rsp_tready),
      .can_step  (can_step),
      .out_valid (rsp_tvalid),
      .out_digit (out_digit),
      .out_index (out_index),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - DIGIT_W - INDEX_W)'(0), out_index, out_digit};

endmodule

`default_nettype wire

/* hdl/swdr_checker.sv */
// port-level checker for the signed window digit recoder, bound to the top level
// depends on signed_window_digit_recoder_macros.svh and swdr_pkg
`include "signed_window_digit_recoder_macros.svh"
`default_nettype none

module swdr_checker #(
   parameter int MAX_WINDOWS = 64
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [swdr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic                                rsp_tlast,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready
);
   import swdr_pkg::*;

   localparam logic [INDEX_W-1:0] IdxLast = INDEX_W'(MAX_WINDOWS - 1);

   logic [INDEX_W-1:0] rsp_index;
   assign rsp_index = rsp_tdata[DIGIT_W+INDEX_W-1:DIGIT_W];

   `SWDR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp item changed while stalled")
   `SWDR_ASSERT_NEXT(a_one_scalar, clock, reset, req_tvalid && req_tready, !req_tready, "second scalar taken while windows remain")
   `SWDR_ASSERT_NOW(a_cap_last, clock, reset, rsp_tvalid && (rsp_index == IdxLast), rsp_tlast, "window at the cap not marked last")
   `SWDR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "rsp item present after reset")

endmodule

bind signed_window_digit_recoder swdr_checker #(
   .MAX_WINDOWS (MAX_WINDOWS)
) u_swdr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

/* tb/tb_signed_window_digit_recoder.sv */
// self-checking testbench of the signed window digit recoder: scalars in, window digits out
// depends on swdr_pkg and signed_window_digit_recoder; predicts digits from its own
// copy of window_width and scalar_length and checks every window item in order
module tb_signed_window_digit_recoder;
   timeunit 1ns;
   timeprecision 1ps;
   import swdr_pkg::*;

   localparam int SCALAR_W    = 256;
   localparam int WINDOW_CAP  = 64;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = 10;
   localparam int PAD_W       = CSR_DATA_W - WIDTH_W;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [INDEX_W-1:0] index;
      logic               last;
   } window_item_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = REG_WINDOW_WIDTH;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // shadow of the block's registers, changed only while it is idle
   logic [WIDTH_W-1:0]      cfg_width  = WIDTH_RESET;
   logic [LEN_W-1:0]        cfg_length = LEN_RESET;

   logic [REQ_DATA_W-1:0]   pending_scalars[$];
   window_item_type         expected_windows[$];
   window_item_type         oldest_window;
   int                      failures    = 0;
   int                      send_gap    = 0;
   int                      stall_left  = 0;
   int                      quiet_cycles = 0;
   bit                      quiet_phase = 1'b0;

   signed_window_digit_recoder #(
      .SCALAR_WIDTH(SCALAR_W),
      .MAX_WINDOWS (WINDOW_CAP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int clamp_width();
      int c;
      c = int'(cfg_width);
      if (c < int'(WIDTH_MIN)) c = int'(WIDTH_MIN);
      if (c > int'(WIDTH_MAX)) c = int'(WIDTH_MAX);
      return c;
   endfunction

   // cut one scalar into windows under the current register values
   function automatic void recode_scalar(input logic [REQ_DATA_W-1:0] scalar);
      int                    c;
      int                    len;
      int                    count;
      int                    off;
      int                    d;
      int                    carry;
      bit                    signed_mode;
      logic [REQ_DATA_W-1:0] shifted;
      window_item_type       w_item;
      c = clamp_width();
      len = int'(cfg_length);
      if (len < 1) len = 1;
      if (len > SCALAR_W) len = SCALAR_W;
      signed_mode = (c >= int'(SIGNED_FROM));
      count = signed_mode ? len / c + 1 : (len + c - 1) / c;
      if (count > WINDOW_CAP) count = WINDOW_CAP;
      carry = 0;
      for (int w = 0; w < count; w++) begin
         off = w * c;
         d = 0;
         // a window starting below the length reads all its bits, even those above it
         if (off < len) begin
            shifted = scalar >> off;
            d = int'(shifted[RAW_W-1:0]) & ((1 << c) - 1);
         end
         if (signed_mode) begin
            d += carry;
            carry = 0;
            if (d > (1 << (c - 1))) begin
               d -= (1 << c);
               carry = 1;
            end
         end
         w_item.digit = d[DIGIT_W-1:0];
         w_item.index = w[INDEX_W-1:0];
         w_item.last  = (w + 1 == count);
         expected_windows.push_back(w_item);
      end
   endfunction

   function automatic logic [REQ_DATA_W-1:0] tile_windows(input int c, input int value);
      logic [REQ_DATA_W-1:0] r;
      r = '0;
      for (int off = 0; off < SCALAR_W; off += c) begin
         r |= REQ_DATA_W'(value) << off;
      end
      return r;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] random_scalar();
      logic [REQ_DATA_W-1:0] r;
      int                    c;
      int                    half;
      int                    kind;
      int                    v;
      r = '0;
      c = clamp_width();
      half = 1 << (c - 1);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         for (int i = 0; i < REQ_DATA_W / 32; i++) r[i*32 +: 32] = $urandom;
      end else if (kind < 8) begin
         // windows near the recoding threshold drive long carry chains
         for (int off = 0; off < SCALAR_W; off += c) begin
            case ($urandom_range(0, 5))
               0: v = 0;
               1: v = half;
               2: v = half + 1;
               3: v = half - 1;
               4: v = (1 << c) - 1;
               default: v = $urandom_range(0, (1 << c) - 1);
            endcase
            r |= REQ_DATA_W'(v) << off;
         end
      end else if (kind == 8) begin
         for (int i = $urandom_range(1, 6); i > 0; i--)
            r[$urandom_range(0, SCALAR_W - 1)] = 1'b1;
      end else begin
         r[$urandom_range(0, 3)*LIMB_W +: LIMB_W] = {$urandom, $urandom};
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_phase || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // sender side: predicts on acceptance, then loads the next scalar after its gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) recode_scalar(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_scalars.size() != 0) begin
               req_tdata  <= pending_scalars.pop_front();
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver side: stalls at random and checks each window item against the oldest one due
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_windows.size() == 0) begin
               $error("unexpected window item: tdata %h tlast %b", rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               oldest_window = expected_windows.pop_front();
               if (rsp_tdata[DIGIT_W-1:0] !== oldest_window.digit) begin
                  $error("window_digit: expected %0d, got %0d",
                         $signed(oldest_window.digit), $signed(rsp_tdata[DIGIT_W-1:0]));
                  failures++;
               end
               if (rsp_tdata[DIGIT_W +: INDEX_W] !== oldest_window.index) begin
                  $error("window_index: expected %0d, got %0d",
                         oldest_window.index, rsp_tdata[DIGIT_W +: INDEX_W]);
                  failures++;
               end
               if (rsp_tlast !== oldest_window.last) begin
                  $error("last_digit: expected %0b, got %0b", oldest_window.last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("signed_window_digit_recoder regression: fail");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      while (pending_scalars.size() != 0 || req_tvalid || expected_windows.size() != 0)
         @(posedge clock);
   endtask

   // both registers are rewritten only once every window of the last scalar is out
   task automatic configure(input logic [WIDTH_W-1:0] width, input logic [LEN_W-1:0] len_value);
      logic [PAD_W-1:0] junk;
      junk = PAD_W'($urandom);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= REG_WINDOW_WIDTH;
      csr_wdata <= {junk, width};
      cfg_width = width;
      @(posedge clock);
      csr_addr  <= REG_SCALAR_LENGTH;
      csr_wdata <= len_value;
      cfg_length = len_value;
      @(posedge clock);
      csr_we <= 1'b0;
      quiet_phase = ($urandom_range(0, 3) == 0);
   endtask

   task automatic random_phase(input logic [WIDTH_W-1:0] width,
                               input logic [LEN_W-1:0] len_value);
      configure(width, len_value);
      for (int i = 0; i < 11; i++) pending_scalars.push_back(random_scalar());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values: width 7, length 256
      pending_scalars.push_back('0);
      pending_scalars.push_back('1);
      pending_scalars.push_back({(REQ_DATA_W/8){8'h55}});
      pending_scalars.push_back({(REQ_DATA_W/8){8'hAA}});
      pending_scalars.push_back(tile_windows(7, 64));
      pending_scalars.push_back(tile_windows(7, 65));
      pending_scalars.push_back(tile_windows(7, 127));
      pending_scalars.push_back(REQ_DATA_W'(1) << 255 | REQ_DATA_W'(1) << 63
                                | REQ_DATA_W'(1) << 128);

      // top window starts below the length but reaches past it: its carry is dropped
      configure(4'd8, 9'd255);
      pending_scalars.push_back('1);
      pending_scalars.push_back(tile_windows(8, 128));
      pending_scalars.push_back(tile_windows(8, 129));
      pending_scalars.push_back(REQ_DATA_W'(1) << 254);

      // unsigned digits, most windows
      configure(4'd4, 9'd256);
      pending_scalars.push_back('0);
      pending_scalars.push_back('1);
      pending_scalars.push_back(random_scalar());

      // width above range, single window that reads bits above the length
      configure(4'd15, 9'd1);
      pending_scalars.push_back('1);
      pending_scalars.push_back(tile_windows(14, 8193));

      // width below range and zero length
      configure(4'd0, 9'd0);
      pending_scalars.push_back('1);

      // length above the scalar width
      configure(4'd14, 9'd511);
      pending_scalars.push_back('1);
      pending_scalars.push_back(random_scalar());

      random_phase(4'd7, 9'd256);
      random_phase(4'd4, 9'd255);
      random_phase(4'd5, 9'd256);
      random_phase(4'd6, 9'd130);
      random_phase(4'd9, 9'd200);
      random_phase(4'd10, 9'd256);
      random_phase(4'd11, 9'd97);
      random_phase(4'd12, 9'd256);
      random_phase(4'd13, 9'd250);
      random_phase(4'd14, 9'd256);
      random_phase(4'd7, 9'd1);
      random_phase(4'd3, 9'd300);
      random_phase(WIDTH_W'($urandom_range(0, 15)), LEN_W'($urandom_range(0, 511)));
      random_phase(WIDTH_W'($urandom_range(7, 14)), LEN_W'($urandom_range(1, 256)));

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (failures == 0) begin
         $display("signed_window_digit_recoder regression: pass");
      end else begin
         $display("signed_window_digit_recoder regression: fail");
      end
      $finish;
   end

endmodule
